// File: hw/rtl/mmc3ob_pkg.sv
// Shared types and constants for the MMC3 outer bank mapper.
`default_nettype none

package mmc3ob_pkg;

    // Item kinds carried in the action field
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_PRG   = 2'd2,
        ACT_CHR   = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic CFG_PRG_BANKS   = 1'b0;
    localparam logic CFG_FOUR_SCREEN = 1'b1;

    // Address decode
    localparam logic [15:0] INNER_DECODE_MASK = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT   = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA     = 16'h8001;
    localparam logic [15:0] REG_MIRROR        = 16'hA000;
    localparam logic [15:0] REG_IRQ_LATCH     = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD    = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE   = 16'hE000;
    localparam logic [15:0] REG_IRQ_ENABLE    = 16'hE001;
    localparam logic [3:0]  OUTER_PAGE        = 4'h5;
    localparam logic [2:0]  OUTER_MASKED_IDX  = 3'd2;

    localparam int PRG_BANKS_W = 13;
    localparam int BANK_W      = 13;
    localparam logic [PRG_BANKS_W-1:0] PRG_BANKS_RESET = 13'd32;

    typedef struct packed {
        t_action     action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        in_vblank;
        logic        rendering_on;
    } t_in_item;

    typedef struct packed {
        logic [BANK_W-1:0] mapped_bank;
        logic              irq_pulse;
        logic              mirror_horizontal;
    } t_out_item;

    // Register view that the bank lookup works from
    typedef struct packed {
        logic [PRG_BANKS_W-1:0] prg_banks;
        logic [7:0]             bank_select;
        logic [7:0][7:0]        inner_banks;
        logic [3:0][7:0]        outer_regs;
    } t_map_regs;

endpackage

`default_nettype wire

// File: hw/rtl/mmc3ob_regs.sv
// Mapper register file: configuration, MMC3 and outer registers, IRQ counter.
`default_nettype none

module mmc3ob_regs (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_index,
    input  wire logic [12:0]           i_cfg_data,
    input  wire logic                  i_accept,
    input  wire mmc3ob_pkg::t_in_item  i_item,
    output      mmc3ob_pkg::t_map_regs o_regs,
    output      logic                  o_pulse,
    output      logic                  o_mirror
);
    import mmc3ob_pkg::*;

    logic [PRG_BANKS_W-1:0] r_prg_banks;
    logic                   r_four_screen;
    logic [7:0]             r_bank_select, n_bank_select;
    logic [7:0][7:0]        r_inner, n_inner;
    logic [3:0][7:0]        r_outer, n_outer;
    logic [7:0]             r_reload, n_reload;
    logic [8:0]             r_count, n_count;
    logic                   r_armed, n_armed;
    logic                   r_pending, n_pending;
    logic                   r_mirror, n_mirror;

    logic [2:0]  outer_idx;
    logic [7:0]  outer_val;
    logic [7:0]  old2;
    logic [8:0]  count_dec;

    // Mask the outer register 2 write from its old value
    always_comb begin
        outer_idx = i_item.address[2:0];
        old2      = r_outer[2];
        outer_val = i_item.write_data;
        if (old2[7]) begin
            outer_val = {old2[7:4], i_item.write_data[3:0]};
        end
        outer_val = outer_val & {4'hF, ~old2[6:4], 1'b1};
        count_dec = r_count - 9'd1;
    end

    // Work out the next register state for the accepted transaction
    always_comb begin
        n_bank_select = r_bank_select;
        n_inner       = r_inner;
        n_outer       = r_outer;
        n_reload      = r_reload;
        n_count       = r_count;
        n_armed       = r_armed;
        n_pending     = r_pending;
        n_mirror      = r_mirror;
        o_pulse       = 1'b0;
        if (i_accept) begin
            case (i_item.action)
                ACT_WRITE: begin
                    if (i_item.address[15:12] == OUTER_PAGE) begin
                        if (!outer_idx[2] &&
                            (!r_outer[3][7] || outer_idx == OUTER_MASKED_IDX)) begin
                            n_outer[outer_idx[1:0]] = (outer_idx == OUTER_MASKED_IDX) ?
                                                      outer_val : i_item.write_data;
                        end
                    end else if (i_item.address[15]) begin
                        case (i_item.address & INNER_DECODE_MASK)
                            REG_BANK_SELECT: n_bank_select = i_item.write_data;
                            REG_BANK_DATA:   n_inner[r_bank_select[2:0]] = i_item.write_data;
                            REG_MIRROR: begin
                                if (!r_four_screen) begin
                                    n_mirror = i_item.write_data[0];
                                end
                            end
                            REG_IRQ_LATCH:   n_reload = i_item.write_data;
                            REG_IRQ_RELOAD:  n_pending = 1'b1;
                            REG_IRQ_DISABLE: n_armed = 1'b0;
                            REG_IRQ_ENABLE:  n_armed = 1'b1;
                            default: ;
                        endcase
                        // Any MMC3 write reloads the counter while a reload is pending
                        if (n_pending) begin
                            n_count = {1'b0, n_reload};
                        end
                    end
                end
                ACT_TICK: begin
                    if (!i_item.in_vblank && i_item.rendering_on && !r_count[8]) begin
                        n_pending = 1'b0;
                        n_count   = count_dec;
                        if (count_dec[8] && r_armed) begin
                            n_pending = 1'b1;
                            o_pulse   = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold configuration and mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_banks   <= PRG_BANKS_RESET;
            r_four_screen <= 1'b0;
            r_bank_select <= '0;
            r_inner       <= '0;
            r_outer       <= '0;
            r_reload      <= '0;
            r_count       <= '0;
            r_armed       <= 1'b0;
            r_pending     <= 1'b0;
            r_mirror      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PRG_BANKS:   r_prg_banks <= i_cfg_data;
                    CFG_FOUR_SCREEN: r_four_screen <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_bank_select <= n_bank_select;
            r_inner       <= n_inner;
            r_outer       <= n_outer;
            r_reload      <= n_reload;
            r_count       <= n_count;
            r_armed       <= n_armed;
            r_pending     <= n_pending;
            r_mirror      <= n_mirror;
        end
    end

    assign o_regs.prg_banks   = r_prg_banks;
    assign o_regs.bank_select = r_bank_select;
    assign o_regs.inner_banks = r_inner;
    assign o_regs.outer_regs  = r_outer;
    assign o_mirror           = n_mirror;

endmodule

`default_nettype wire

// File: hw/rtl/mmc3ob_lookup.sv
// PRG and CHR bank lookup with MMC3 and GNROM masks and outer offsets.
`default_nettype none

module mmc3ob_lookup (
    input  wire mmc3ob_pkg::t_map_regs      i_regs,
    input  wire mmc3ob_pkg::t_action        i_action,
    input  wire logic [15:0]                i_address,
    output      logic [mmc3ob_pkg::BANK_W-1:0] o_bank
);
    import mmc3ob_pkg::*;

    logic [7:0]  e0, e1, e2, e3;
    logic [7:0]  fixed_base, prg_last, prg_second, prg_bank;
    logic [7:0]  prg_m_mmc3;
    logic [1:0]  prg_m_gn;
    logic [12:0] prg_off, prg_out;
    logic [2:0]  slot;
    logic [7:0]  chr_bank, chr_m_mmc3;
    logic [2:0]  chr_m_gn;
    logic [12:0] chr_off, chr_out;

    assign e0 = i_regs.outer_regs[0];
    assign e1 = i_regs.outer_regs[1];
    assign e2 = i_regs.outer_regs[2];
    assign e3 = i_regs.outer_regs[3];

    // Pick the inner PRG bank for the 8 KB window
    always_comb begin
        fixed_base = {i_regs.prg_banks[6:0], 1'b0};
        prg_last   = fixed_base - 8'd1;
        prg_second = fixed_base - 8'd2;
        case (i_address[14:13])
            2'd0:    prg_bank = i_regs.bank_select[6] ? prg_second : i_regs.inner_banks[6];
            2'd1:    prg_bank = i_regs.inner_banks[7];
            2'd2:    prg_bank = i_regs.bank_select[6] ? i_regs.inner_banks[6] : prg_second;
            default: prg_bank = prg_last;
        endcase
    end

    // Apply the outer PRG masks and offset
    always_comb begin
        prg_m_mmc3 = {e1[5], e1[6], ~e1[7], ~e0[6], {4{~e3[4]}}};
        prg_m_gn   = e3[4] ? {e1[1], 1'b1} : 2'b00;
        prg_off    = {~e1[0], e0[5:4], e1[3:2], e1[4], e0[2:0], e3[3:1], 1'b0};
        prg_off    = prg_off & ~{5'd0, prg_m_mmc3[7:2], prg_m_mmc3[1] | prg_m_gn[1],
                                 prg_m_mmc3[0] | prg_m_gn[0]};
        prg_out    = {5'd0, prg_bank & prg_m_mmc3} | prg_off
                   | {11'd0, i_address[14:13] & prg_m_gn};
    end

    // Pick the inner CHR bank for the 1 KB window, honoring the half swap
    always_comb begin
        slot = i_address[12:10] ^ {i_regs.bank_select[7], 2'b00};
        if (!slot[2]) begin
            chr_bank = {i_regs.inner_banks[{2'b00, slot[1]}][7:1], slot[0]};
        end else begin
            chr_bank = i_regs.inner_banks[slot - 3'd2];
        end
    end

    // Apply the outer CHR masks and offset
    always_comb begin
        chr_m_mmc3 = e3[4] ? 8'h00 : (e0[7] ? 8'h7F : 8'hFF);
        chr_m_gn   = e3[4] ? 3'b111 : 3'b000;
        chr_off    = {1'b0, e0[2:1], e0[5:3], e2[3:0], 3'b000};
        chr_off    = chr_off & ~{5'd0, chr_m_mmc3[7:3], chr_m_mmc3[2:0] | chr_m_gn};
        chr_out    = {5'd0, chr_bank & chr_m_mmc3} | chr_off
                   | {10'd0, i_address[12:10] & chr_m_gn};
    end

    // Select the lookup result; writes, ticks and unmapped addresses give zero
    always_comb begin
        o_bank = '0;
        case (i_action)
            ACT_PRG: begin
                if (i_address[15]) begin
                    o_bank = prg_out;
                end
            end
            ACT_CHR: begin
                if (i_address[15:13] == 3'd0) begin
                    o_bank = chr_out;
                end
            end
            default: o_bank = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/mmc3_outer_bank_mapper_top.sv
// Top level of the MMC3 outer bank mapper: input handshake and result register.
//
// Input channel: one transaction per item (CPU write, scanline tick, PRG
// lookup or CHR lookup), taken when i_in_valid is high and o_in_stall low.
// Output channel: one result per item, taken when o_out_valid is high and
// i_out_stall low. Results leave in item order.
// The result is registered and appears in the cycle after its item is taken.
// Throughput is one item per cycle while not stalled; the register update, IRQ
// counter step and bank mapping are one pass of logic between the input and
// the result register. A new item is taken while a result waits, as long as
// that result is taken in the same cycle; o_in_stall rises only when the result
// register is full and the receiver stalls; the held result stays unchanged.
// Configuration: i_cfg_valid/o_cfg_ready write register i_cfg_index
// (0 PRG 16 KB bank count, 1 four-screen flag); o_cfg_ready is always high.
// Write it only while the block is idle.
// Reset (synchronous, active low): all mapper registers clear, the PRG bank
// count returns to 32, four-screen clears and the output is empty.
`default_nettype none

module mmc3_outer_bank_mapper_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [12:0]           i_cfg_data,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire mmc3ob_pkg::t_in_item  i_in,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      mmc3ob_pkg::t_out_item o_out
);
    import mmc3ob_pkg::*;

    logic              accept;
    t_map_regs         regs;
    logic              pulse;
    logic              mirror;
    logic [BANK_W-1:0] bank;
    logic              r_out_valid;
    t_out_item         r_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;

    mmc3ob_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in),
        .o_regs      (regs),
        .o_pulse     (pulse),
        .o_mirror    (mirror)
    );

    mmc3ob_lookup u_lookup (
        .i_regs    (regs),
        .i_action  (i_in.action),
        .i_address (i_in.address),
        .o_bank    (bank)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.mapped_bank       <= bank;
            r_out.irq_pulse         <= pulse;
            r_out.mirror_horizontal <= mirror;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: tb/tb_mmc3_outer_bank_mapper_top.sv
// Self-checking testbench for the MMC3 outer bank mapper top level.
`timescale 1ns / 1ps

module tb_mmc3_outer_bank_mapper_top;
    import mmc3ob_pkg::*;

    localparam logic [2:0] OUTER_LOCK_IDX = 3'd3;
    localparam int         LONG_HOLD_CYCLES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_PRG_BANKS;
    logic [12:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out;

    // Mapper state as the checker sees it
    logic [12:0] cfg_prg16 = PRG_BANKS_RESET;
    logic        cfg_four_scr = 1'b0;
    logic [7:0]  sel_reg = '0;
    logic [7:0]  mmc3_bank [8] = '{default: 8'h00};
    logic [7:0]  outer_reg [4] = '{default: 8'h00};
    logic [7:0]  irq_latch = '0;
    logic [8:0]  irq_counter = '0;
    logic        irq_enabled = 1'b0;
    logic        reload_flag = 1'b0;
    logic        mirror_h = 1'b0;

    t_in_item  pending_items [$];
    t_out_item results_due [$];
    int        items_offered = 0;
    int        items_taken = 0;
    int        queued_count = 0;
    int        mismatch_count = 0;

    // Traffic shaping flags set by the stimulus process, plus sender and receiver counters
    bit lock_ok = 1'b0;
    bit last_phase = 1'b0;
    bit snd_idle_on = 1'b1;
    bit rcv_idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;

    mmc3_outer_bank_mapper_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Apply outer masks and offsets to an 8 KB PRG bank
    function automatic logic [12:0] prg_bank_at(logic [15:0] a);
        int unsigned n, last_b, second_b, b, e0, e1, e3, mm, mg, off;
        if (!a[15]) return '0;
        n = cfg_prg16;
        last_b = (n * 2 - 1) & 32'hFF;
        second_b = (n * 2 - 2) & 32'hFF;
        case (a[14:13])
            2'd0: b = sel_reg[6] ? second_b : mmc3_bank[6];
            2'd1: b = mmc3_bank[7];
            2'd2: b = sel_reg[6] ? mmc3_bank[6] : second_b;
            default: b = last_b;
        endcase
        e0 = outer_reg[0];
        e1 = outer_reg[1];
        e3 = outer_reg[3];
        mm = (e3[4] ? 0 : 32'h0F) | (e0[6] ? 0 : 32'h10) | (e1[7] ? 0 : 32'h20)
           | (e1[6] ? 32'h40 : 0) | (e1[5] ? 32'h80 : 0);
        mg = e3[4] ? (e1[1] ? 32'h3 : 32'h1) : 0;
        off = (e3 & 32'h0E) | ((e0 << 4) & 32'h70) | ((e1 << 3) & 32'h80)
            | ((e1 << 6) & 32'h300) | ((e0 << 6) & 32'hC00) | ((~e1 << 12) & 32'h1000);
        off = off & ~(mm | mg);
        return 13'(((b & mm) | off | ((32'(a) >> 13) & mg)) & 32'h1FFF);
    endfunction

    // Resolve the 1 KB CHR bank, honoring the inversion bit at once
    function automatic logic [12:0] chr_bank_at(logic [15:0] a);
        int unsigned s, b, e0, e2, e3, mm, mg, off;
        if (a >= 16'h2000) return '0;
        s = a[12:10] ^ (sel_reg[7] ? 3'd4 : 3'd0);
        if (s < 4) b = (mmc3_bank[s >> 1] & 8'hFE) + (s & 1);
        else b = mmc3_bank[s - 2];
        e0 = outer_reg[0];
        e2 = outer_reg[2];
        e3 = outer_reg[3];
        mm = e3[4] ? 0 : (e0[7] ? 32'h7F : 32'hFF);
        mg = e3[4] ? 32'h7 : 0;
        off = ((e0 << 9) & 32'hC00) | ((e0 << 4) & 32'h380) | ((e2 << 3) & 32'h78);
        off = off & ~(mm | mg);
        return 13'(((b & mm) | off | ((32'(a) >> 10) & mg)) & 32'h1FFF);
    endfunction

    // Advance the mapper state by one transaction and form its result
    task automatic mapper_step(input t_in_item it, output t_out_item res);
        logic [7:0]  d;
        logic [7:0]  old;
        logic [2:0]  idx;
        logic [12:0] bank;
        logic        pulse;
        d = it.write_data;
        bank = '0;
        pulse = 1'b0;
        case (it.action)
            ACT_WRITE: begin
                if (it.address[15:12] == OUTER_PAGE) begin
                    idx = it.address[2:0];
                    if (!(outer_reg[3][7] && idx != OUTER_MASKED_IDX)) begin
                        if (idx == OUTER_MASKED_IDX) begin
                            old = outer_reg[2];
                            if (old[7]) d = {old[7:4], d[3:0]};
                            d = d & {4'hF, ~old[6:4], 1'b1};
                        end
                        if (!idx[2]) outer_reg[idx[1:0]] = d;
                    end
                end else if (it.address[15]) begin
                    case (it.address & INNER_DECODE_MASK)
                        REG_BANK_SELECT: sel_reg = d;
                        REG_BANK_DATA:   mmc3_bank[sel_reg[2:0]] = d;
                        REG_MIRROR:      if (!cfg_four_scr) mirror_h = d[0];
                        REG_IRQ_LATCH:   irq_latch = d;
                        REG_IRQ_RELOAD: begin
                            reload_flag = 1'b1;
                            irq_counter = {1'b0, irq_latch};
                        end
                        REG_IRQ_DISABLE: irq_enabled = 1'b0;
                        REG_IRQ_ENABLE:  irq_enabled = 1'b1;
                        default: ;
                    endcase
                    // Any MMC3 write reloads the counter while a reload is pending
                    if (reload_flag) irq_counter = {1'b0, irq_latch};
                end
            end
            ACT_TICK: begin
                // Hold the counter once it has gone negative
                if (!it.in_vblank && it.rendering_on && !irq_counter[8]) begin
                    reload_flag = 1'b0;
                    irq_counter = irq_counter - 9'd1;
                    if (irq_counter[8] && irq_enabled) begin
                        reload_flag = 1'b1;
                        pulse = 1'b1;
                    end
                end
            end
            ACT_PRG: bank = prg_bank_at(it.address);
            default: bank = chr_bank_at(it.address);
        endcase
        res.mapped_bank = bank;
        res.irq_pulse = pulse;
        res.mirror_horizontal = mirror_h;
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    // Keep outer lock and sticky register 2 bits out until the closing phase
    task automatic queue_item(input t_action act, input logic [15:0] a,
                              input logic [7:0] d, input bit vb, input bit ro);
        t_in_item it;
        if (!lock_ok && act == ACT_WRITE && a[15:12] == OUTER_PAGE
                && (a[2:0] == OUTER_MASKED_IDX || a[2:0] == OUTER_LOCK_IDX))
            d[7] = 1'b0;
        it.action = act;
        it.address = a;
        it.write_data = d;
        it.in_vblank = vb;
        it.rendering_on = ro;
        pending_items.push_back(it);
        queued_count = queued_count + 1;
    endtask

    task automatic queue_random(input int n);
        int          start;
        int          k;
        logic [15:0] a;
        start = queued_count;
        while (queued_count - start < n) begin
            a = 16'($urandom);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // Bank program pair: select then data
                    queue_item(ACT_WRITE, {3'b100, a[12:1], 1'b0}, 8'($urandom),
                               bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                    queue_item(ACT_WRITE, {3'b100, a[12:1], 1'b1}, 8'($urandom),
                               bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                end
                2: begin
                    // IRQ setup: latch, reload, enable or disable
                    queue_item(ACT_WRITE, {3'b110, a[12:1], 1'b0},
                               ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 6)),
                               1'b0, 1'b1);
                    queue_item(ACT_WRITE, {3'b110, a[12:1], 1'b1}, 8'($urandom), 1'b0, 1'b1);
                    queue_item(ACT_WRITE, {3'b111, a[12:1], 1'(($urandom_range(0, 3) != 0))},
                               8'($urandom), 1'b1, 1'b0);
                end
                3: begin
                    for (k = 0; k < $urandom_range(1, 5); k++)
                        queue_item(ACT_TICK, 16'($urandom), 8'($urandom),
                                   bit'($urandom_range(0, 5) == 0),
                                   bit'($urandom_range(0, 7) != 0));
                end
                4: queue_item(ACT_WRITE, {4'h5, a[11:0]}, 8'($urandom),
                              bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                5: queue_item(ACT_WRITE, {1'b1, a[14:0]}, 8'($urandom),
                              bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                6: begin
                    // Unmapped CPU space: below 0x5000 or 0x6000-0x6FFF
                    if (a[12]) a[14:12] = {a[14] | a[13], 1'b1, 1'b0};
                    queue_item(ACT_WRITE, {1'b0, a[14:0]}, 8'($urandom),
                               bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                end
                7: begin
                    if ($urandom_range(0, 3) != 0) a[15] = 1'b1;
                    queue_item(ACT_PRG, a, 8'($urandom),
                               bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                end
                8: begin
                    if ($urandom_range(0, 3) != 0) a[15:13] = 3'b000;
                    queue_item(ACT_CHR, a, 8'($urandom),
                               bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
                end
                default: queue_item(t_action'($urandom_range(0, 3)), a, 8'($urandom),
                                    bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
            endcase
        end
    endtask

    // Write one configuration register and mirror it into the checker
    task automatic program_cfg(input logic idx, input logic [12:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PRG_BANKS) cfg_prg16 = val;
        else cfg_four_scr = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued transaction has been taken and answered
    task automatic settle();
        while (pending_items.size() != 0 || i_in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic bit idling_allowed();
        return !(last_phase && pending_items.size() < 50);
    endfunction

    // Sender: hold a stalled transaction, otherwise advance or idle
    always @(negedge i_clk) begin : sender
        t_in_item nxt;
        bit       nv;
        nxt = i_in;
        nv = i_in_valid;
        if (i_rst_n && (!i_in_valid || items_taken == items_offered)) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
            end else if (pending_items.size() > 0) begin
                if (snd_idle_on && idling_allowed() && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 8) - 1;
                end else begin
                    nxt = pending_items.pop_front();
                    nv = 1'b1;
                    items_offered = items_offered + 1;
                end
            end
        end
        i_in_valid <= nv;
        i_in <= nxt;
    end

    // Receiver: random stall bursts plus one long hold-off
    always @(negedge i_clk) begin : receiver
        bit st;
        st = 1'b0;
        if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            st = 1'b1;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            st = 1'b1;
            stall_left = stall_left - 1;
        end else if (rcv_idle_on && idling_allowed() && $urandom_range(0, 4) == 0) begin
            st = 1'b1;
            stall_left = $urandom_range(1, 8) - 1;
        end
        i_out_stall <= st;
    end

    // Monitor: check results in order, predict each accepted transaction
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        t_out_item res;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = o_out;
                if (results_due.size() == 0) begin
                    $display("%0t: result with none pending, expected nothing, got %h",
                             $time, got);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = results_due.pop_front();
                    check_field("mapped_bank", want.mapped_bank, got.mapped_bank);
                    check_field("irq_pulse", want.irq_pulse, got.irq_pulse);
                    check_field("mirror_horizontal", want.mirror_horizontal,
                                got.mirror_horizontal);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                mapper_step(i_in, res);
                results_due.push_back(res);
                items_taken = items_taken + 1;
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lookup bounds, every MMC3 register, IRQ corner cases, outer regs
        queue_item(ACT_PRG,   16'h7FFF, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_PRG,   16'hE000, 8'hFF, 1'b1, 1'b1);
        queue_item(ACT_CHR,   16'h2000, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h8000, 8'hC7, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h8001, 8'hFF, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h8000, 8'h80, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h8001, 8'h13, 1'b0, 1'b0);
        queue_item(ACT_CHR,   16'h1FFF, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_CHR,   16'h0000, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'hA000, 8'h01, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'hC000, 8'h01, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'hC001, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'hE001, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_TICK,  16'h0000, 8'h00, 1'b0, 1'b1);
        queue_item(ACT_TICK,  16'h0000, 8'h00, 1'b1, 1'b1);
        queue_item(ACT_TICK,  16'h0000, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_TICK,  16'hFFFF, 8'hFF, 1'b0, 1'b1);
        queue_item(ACT_TICK,  16'h0000, 8'h00, 1'b0, 1'b1);
        queue_item(ACT_WRITE, 16'hE000, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h6000, 8'hFF, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h5007, 8'hFF, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h5002, 8'h70, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h5002, 8'h0E, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h5003, 8'h1E, 1'b0, 1'b0);
        queue_item(ACT_PRG,   16'hA000, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_CHR,   16'h0C00, 8'h00, 1'b0, 1'b0);
        settle();

        // Bank count of one, four-screen on
        program_cfg(CFG_PRG_BANKS, 13'd1);
        program_cfg(CFG_FOUR_SCREEN, 13'd1);
        queue_random(85);
        settle();

        // Bank count of 4096; the receiver holds off long enough to back up the input
        program_cfg(CFG_PRG_BANKS, 13'd4096);
        program_cfg(CFG_FOUR_SCREEN, 13'd0);
        queue_random(85);
        long_hold_req = 1'b1;
        settle();

        // Bank count of zero, no idling on either side
        snd_idle_on = 1'b0;
        rcv_idle_on = 1'b0;
        program_cfg(CFG_PRG_BANKS, 13'd0);
        program_cfg(CFG_FOUR_SCREEN, 13'd1);
        queue_random(75);
        settle();

        // Bank count at the top of its field
        snd_idle_on = 1'b1;
        rcv_idle_on = 1'b1;
        program_cfg(CFG_PRG_BANKS, 13'h1FFF);
        program_cfg(CFG_FOUR_SCREEN, 13'd0);
        queue_random(75);
        settle();

        // Closing phase: sticky register 2 and the outer lock, then a quiet tail
        program_cfg(CFG_PRG_BANKS, 13'($urandom_range(2, 4095)));
        lock_ok = 1'b1;
        last_phase = 1'b1;
        queue_item(ACT_WRITE, 16'h5002, 8'hFF, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h5002, 8'h00, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h5003, 8'h80, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h5000, 8'hFF, 1'b0, 1'b0);
        queue_item(ACT_WRITE, 16'h5002, 8'h0F, 1'b0, 1'b0);
        queue_item(ACT_PRG,   16'hC000, 8'h00, 1'b0, 1'b0);
        queue_random(90);
        settle();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(2000000);
        $display("simulation failed");
        $finish;
    end

endmodule
